>>> hdl/cso_pkg.sv
// shared types and constants for the capsule-sphere overlap core
`timescale 1ns / 1ps
package cso_pkg;
   // register indexes
   localparam int unsigned REG_CAP_RADIUS = 0;
   localparam int unsigned REG_CYL_RADIUS = 1;
   localparam int unsigned COORD_W        = 32;
   // bits of a dot product sum (three 33x33 products)
   localparam int unsigned DOT_W          = 68;

   typedef logic signed [COORD_W-1:0] coord_type;
endpackage

>>> hdl/capsule_sphere_overlap_core.sv
// capsule against sphere overlap test, pipelined
`timescale 1ns / 1ps
// One query is taken per clock cycle (start while busy is low; busy is tied low).
// done is registered in stage 8 together with the result, once the query has passed
// stages 1 to 4, the FRAC_BITS stages of the restoring divider that forms the
// projection parameter t, and stages 5 to 7. Results cannot be held off by the
// receiver; every transfer is shown for a single cycle. The user must write the cap
// and cylinder radii through the csr_ port only while no query is in flight; the
// block does not enforce this.
module capsule_sphere_overlap_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [31:0]          req_seg_a_x,
   input  logic signed [31:0]          req_seg_a_y,
   input  logic signed [31:0]          req_seg_a_z,
   input  logic signed [31:0]          req_seg_b_x,
   input  logic signed [31:0]          req_seg_b_y,
   input  logic signed [31:0]          req_seg_b_z,
   input  logic signed [31:0]          req_ball_x,
   input  logic signed [31:0]          req_ball_y,
   input  logic signed [31:0]          req_ball_z,
   input  logic [31:0]                 req_ball_radius,
   output logic                        done,
   output logic                        rsp_hit,
   output logic signed [31:0]          rsp_contact_x,
   output logic signed [31:0]          rsp_contact_y,
   output logic signed [31:0]          rsp_contact_z,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [2:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   localparam int DW    = cso_pkg::DOT_W;
   localparam int TW    = FRAC_BITS + 1;
   localparam int NST   = FRAC_BITS;
   localparam logic [TW-1:0] ONE_T = TW'(1) << FRAC_BITS;
   localparam int EPS_I = ((1 << FRAC_BITS) + 500) / 1000;
   localparam logic [TW-1:0] EPS_T = TW'(EPS_I);
   localparam logic [TW-1:0] HI_T  = ONE_T - EPS_T;

   assign busy       = 1'b0;
   assign csr_pready = 1'b1;

   // configuration registers
   logic [31:0] cap_r_ff, cyl_r_ff;
   logic        csr_wr;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_r_ff <= '0;
         cyl_r_ff <= '0;
      end else if (csr_wr) begin
         case (csr_paddr[2])
            1'(cso_pkg::REG_CAP_RADIUS): if (csr_paddr[1:0] == 2'b00) cap_r_ff <= csr_pwdata;
            1'(cso_pkg::REG_CYL_RADIUS): if (csr_paddr[1:0] == 2'b00) cyl_r_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end
   always_comb begin
      case (csr_paddr)
         3'(4*cso_pkg::REG_CAP_RADIUS): csr_prdata = cap_r_ff;
         3'(4*cso_pkg::REG_CYL_RADIUS): csr_prdata = cyl_r_ff;
         default:                       csr_prdata = '0;
      endcase
   end

   // stage 1: differences
   logic              v1_ff;
   logic signed [32:0] ab1_ff [3], ac1_ff [3];
   logic signed [31:0] a1_ff [3], c1_ff [3];
   logic [31:0]        r1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= start;
      a1_ff[0] <= req_seg_a_x; a1_ff[1] <= req_seg_a_y; a1_ff[2] <= req_seg_a_z;
      c1_ff[0] <= req_ball_x;  c1_ff[1] <= req_ball_y;  c1_ff[2] <= req_ball_z;
      ab1_ff[0] <= 33'(req_seg_b_x) - 33'(req_seg_a_x);
      ab1_ff[1] <= 33'(req_seg_b_y) - 33'(req_seg_a_y);
      ab1_ff[2] <= 33'(req_seg_b_z) - 33'(req_seg_a_z);
      ac1_ff[0] <= 33'(req_ball_x) - 33'(req_seg_a_x);
      ac1_ff[1] <= 33'(req_ball_y) - 33'(req_seg_a_y);
      ac1_ff[2] <= 33'(req_ball_z) - 33'(req_seg_a_z);
      r1_ff <= req_ball_radius;
   end

   // stage 2: per-axis products
   logic               v2_ff;
   logic signed [65:0] pn2_ff [3], pd2_ff [3];
   logic signed [32:0] ab2_ff [3];
   logic signed [31:0] a2_ff [3], c2_ff [3];
   logic [31:0]        r2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
      for (int i = 0; i < 3; i++) begin
         pn2_ff[i] <= 66'(ac1_ff[i]) * 66'(ab1_ff[i]);
         pd2_ff[i] <= 66'(ab1_ff[i]) * 66'(ab1_ff[i]);
      end
      ab2_ff <= ab1_ff; a2_ff <= a1_ff; c2_ff <= c1_ff; r2_ff <= r1_ff;
   end

   // stage 3: dot sums
   logic               v3_ff;
   logic signed [DW-1:0] num3_ff;
   logic [DW-1:0]      den3_ff;
   logic signed [32:0] ab3_ff [3];
   logic signed [31:0] a3_ff [3], c3_ff [3];
   logic [31:0]        r3_ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else       v3_ff <= v2_ff;
      num3_ff <= DW'(pn2_ff[0]) + DW'(pn2_ff[1]) + DW'(pn2_ff[2]);
      den3_ff <= DW'(pd2_ff[0]) + DW'(pd2_ff[1]) + DW'(pd2_ff[2]);
      ab3_ff <= ab2_ff; a3_ff <= a2_ff; c3_ff <= c2_ff; r3_ff <= r2_ff;
   end

   // stage 4: select clamp or division path
   logic               v4_ff, cl4_ff;
   logic [TW-1:0]      tc4_ff;
   logic [DW-1:0]      num4_ff, den4_ff;
   logic signed [32:0] ab4_ff [3];
   logic signed [31:0] a4_ff [3], c4_ff [3];
   logic [31:0]        r4_ff;
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else       v4_ff <= v3_ff;
      if (num3_ff <= 0 || den3_ff == '0) begin
         cl4_ff <= 1'b1; tc4_ff <= '0;
      end else if (DW'(num3_ff) >= den3_ff) begin
         cl4_ff <= 1'b1; tc4_ff <= ONE_T;
      end else begin
         cl4_ff <= 1'b0; tc4_ff <= '0;
      end
      num4_ff <= DW'(num3_ff); den4_ff <= den3_ff;
      ab4_ff <= ab3_ff; a4_ff <= a3_ff; c4_ff <= c3_ff; r4_ff <= r3_ff;
   end

   // divider pipeline: one quotient bit per stage
   logic               dv_ff  [NST+1];
   logic               dcl_ff [NST+1];
   logic [TW-1:0]      dq_ff  [NST+1];
   logic [DW:0]        drm_ff [NST+1];
   logic [DW-1:0]      dd_ff  [NST+1];
   logic signed [32:0] dab_ff [NST+1][3];
   logic signed [31:0] da_ff  [NST+1][3], dc_ff [NST+1][3];
   logic [31:0]        dr_ff  [NST+1];
   always_comb begin
      dv_ff[0] = v4_ff; dcl_ff[0] = cl4_ff; dq_ff[0] = tc4_ff;
      drm_ff[0] = {1'b0, num4_ff}; dd_ff[0] = den4_ff;
      dab_ff[0] = ab4_ff; da_ff[0] = a4_ff; dc_ff[0] = c4_ff; dr_ff[0] = r4_ff;
   end
   for (genvar s = 0; s < NST; s++) begin : g_div
      logic [DW:0] sh;
      logic        ge;
      assign sh = drm_ff[s] << 1;
      assign ge = sh >= {1'b0, dd_ff[s]};
      always_ff @(posedge clock) begin
         if (reset) dv_ff[s+1] <= 1'b0;
         else       dv_ff[s+1] <= dv_ff[s];
         dcl_ff[s+1] <= dcl_ff[s];
         dq_ff[s+1]  <= dcl_ff[s] ? dq_ff[s] : {dq_ff[s][TW-2:0], ge};
         drm_ff[s+1] <= ge ? sh - {1'b0, dd_ff[s]} : sh;
         dd_ff[s+1]  <= dd_ff[s];
         dab_ff[s+1] <= dab_ff[s]; da_ff[s+1] <= da_ff[s];
         dc_ff[s+1]  <= dc_ff[s];  dr_ff[s+1] <= dr_ff[s];
      end
   end

   // stage 5: t times axis length, radius select
   logic               v5_ff;
   logic [32+TW-1:0]   m5_ff [3];
   logic [2:0]         neg5_ff;
   logic signed [31:0] a5_ff [3], c5_ff [3];
   logic [32:0]        rs5_ff;
   logic [TW-1:0]      t;
   assign t = dq_ff[NST];
   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else       v5_ff <= dv_ff[NST];
      for (int i = 0; i < 3; i++) begin
         m5_ff[i] <= (32+TW)'(dab_ff[NST][i] < 0 ? -dab_ff[NST][i] : dab_ff[NST][i])
                     * (32+TW)'(t);
         neg5_ff[i] <= dab_ff[NST][i] < 0;
      end
      a5_ff <= da_ff[NST]; c5_ff <= dc_ff[NST];
      rs5_ff <= 33'(dr_ff[NST]) + 33'((t <= EPS_T || t >= HI_T) ? cap_r_ff : cyl_r_ff);
   end

   // stage 6: closest point, distance vector
   logic               v6_ff;
   logic signed [31:0] p6_ff [3];
   logic [32:0]        dm6_ff [3];
   logic [32:0]        rs6_ff;
   always_ff @(posedge clock) begin
      logic [32+TW-1:0]  d;
      logic signed [34:0] p, dl;
      if (reset) v6_ff <= 1'b0;
      else       v6_ff <= v5_ff;
      for (int i = 0; i < 3; i++) begin
         d  = (m5_ff[i] + ((32+TW)'(1) << (FRAC_BITS-1))) >> FRAC_BITS;
         p  = neg5_ff[i] ? 35'(a5_ff[i]) - 35'(d) : 35'(a5_ff[i]) + 35'(d);
         dl = 35'(c5_ff[i]) - p;
         p6_ff[i]  <= p[31:0];
         dm6_ff[i] <= 33'(dl < 0 ? -dl : dl);
      end
      rs6_ff <= rs5_ff;
   end

   // stage 7: squares
   logic               v7_ff;
   logic [65:0]        sq7_ff [3];
   logic [65:0]        rr7_ff;
   logic signed [31:0] p7_ff [3];
   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else       v7_ff <= v6_ff;
      for (int i = 0; i < 3; i++) sq7_ff[i] <= 66'(dm6_ff[i]) * 66'(dm6_ff[i]);
      rr7_ff <= 66'(rs6_ff) * 66'(rs6_ff);
      p7_ff <= p6_ff;
   end

   // stage 8: compare and result transfer
   logic [67:0] dist_sum;
   logic        hit;
   assign dist_sum = 68'(sq7_ff[0]) + 68'(sq7_ff[1]) + 68'(sq7_ff[2]);
   assign hit      = dist_sum <= 68'(rr7_ff);
   always_ff @(posedge clock) begin
      if (reset) done <= 1'b0;
      else       done <= v7_ff;
      rsp_hit       <= hit;
      rsp_contact_x <= hit ? p7_ff[0] : '0;
      rsp_contact_y <= hit ? p7_ff[1] : '0;
      rsp_contact_z <= hit ? p7_ff[2] : '0;
   end
endmodule
